FILE: sv/tcrw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcrw_pkg: shared types and constants of the Reno congestion window engine
// Event codes, status and mode codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package tcrw_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int WIN_BITS       = 16;
    localparam int THR_BITS       = 4;
    localparam int TMO_BITS       = 8;
    localparam int OP_BITS        = 2;
    localparam int STATUS_BITS    = 3;
    localparam int MODE_BITS      = 2;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    // reset values of the registers
    localparam logic [WIN_BITS-1:0] TOTAL_RST    = '0;
    localparam logic [THR_BITS-1:0] DUP_THR_RST  = 4'd3;
    localparam logic [TMO_BITS-1:0] TMO_WAIT_RST = 8'd1;
    localparam logic                FAST_REC_RST = 1'b1;
    localparam logic [WIN_BITS-1:0] INIT_CWND_RST = 16'd1;
    localparam logic [WIN_BITS-1:0] INIT_SST_RST  = 16'd64;

    typedef enum logic [OP_BITS-1:0] {
        OP_RESTART    = 2'd0,
        OP_PACKET     = 2'd1,
        OP_LOSS_CHECK = 2'd2,
        OP_RTT_TICK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_NOT_SENT   = 3'd0,
        ST_ACKED      = 3'd1,
        ST_LOST       = 3'd2,
        ST_DUP_ACK    = 3'd3,
        ST_THRESHOLD  = 3'd4
    } t_status;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_SLOW_START = 2'd0,
        MODE_ADDITIVE   = 2'd1,
        MODE_FAST_RETX  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TOTAL_PACKETS    = 3'd0,
        CFG_DUP_ACK_THRESH   = 3'd1,
        CFG_TIMEOUT_WAIT     = 3'd2,
        CFG_FAST_RECOVERY    = 3'd3,
        CFG_INITIAL_CWND     = 3'd4,
        CFG_INITIAL_SSTHRESH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [STATUS_BITS-1:0] packet_status;
        logic                   loss_reacted;
        logic [WIN_BITS-1:0]    window;
        logic [WIN_BITS-1:0]    threshold;
        logic [MODE_BITS-1:0]   cc_mode;
        logic [WIN_BITS-1:0]    acked_total;
        logic [TMO_BITS-1:0]    timeout_left;
        logic                   all_acked;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/tcrw_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcrw_in_if: event channel
// Valid/ready channel that carries one congestion control event.
// ----------------------------------------------------------------------------
interface tcrw_in_if import tcrw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_BITS-1:0] op;
    logic               lost;
    logic               first_of_round;

    modport source (output valid, op, lost, first_of_round, input ready);
    modport sink   (input valid, op, lost, first_of_round, output ready);
endinterface
`default_nettype wire

FILE: sv/tcrw_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcrw_out_if: result channel
// Valid/ready channel that carries the window state after one event.
// ----------------------------------------------------------------------------
interface tcrw_out_if import tcrw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] packet_status;
    logic                   loss_reacted;
    logic [WIN_BITS-1:0]    window;
    logic [WIN_BITS-1:0]    threshold;
    logic [MODE_BITS-1:0]   cc_mode;
    logic [WIN_BITS-1:0]    acked_total;
    logic [TMO_BITS-1:0]    timeout_left;
    logic                   all_acked;

    modport source (output valid, packet_status, loss_reacted, window, threshold, cc_mode,
                    acked_total, timeout_left, all_acked, input ready);
    modport sink   (input valid, packet_status, loss_reacted, window, threshold, cc_mode,
                    acked_total, timeout_left, all_acked, output ready);
endinterface
`default_nettype wire

FILE: sv/tcrw_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcrw_engine: window state and event logic
// Holds the registers and the run state, and computes the next state and the
// result of one event in a single pass.
// ----------------------------------------------------------------------------
module tcrw_engine import tcrw_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire logic    i_accept,
    input  wire t_op     i_op,
    input  wire logic    i_lost,
    input  wire logic    i_first,
    output t_result      o_result
);

    localparam int CW = (COUNT_BITS > WIN_BITS) ? COUNT_BITS : WIN_BITS;
    localparam int EW = CW + 1;

    // registers
    logic [WIN_BITS-1:0] r_total;
    logic [THR_BITS-1:0] r_dup_thr;
    logic [TMO_BITS-1:0] r_tmo_wait;
    logic                r_fast_rec;
    logic [WIN_BITS-1:0] r_init_cwnd;
    logic [WIN_BITS-1:0] r_init_sst;

    // run state
    logic [WIN_BITS-1:0]   r_cwnd,    n_cwnd;
    logic [WIN_BITS-1:0]   r_sst,     n_sst;
    t_mode                 r_mode,    n_mode;
    logic [TMO_BITS-1:0]   r_tmo,     n_tmo;
    logic [COUNT_BITS-1:0] r_acked,   n_acked;
    logic [COUNT_BITS-1:0] r_start,   n_start;
    logic [COUNT_BITS-1:0] r_sent,    n_sent;
    logic [COUNT_BITS-1:0] r_lostcnt, n_lostcnt;
    logic [THR_BITS-1:0]   r_aal,     n_aal;
    logic                  r_open,    n_open;

    t_status status;
    logic    reacted;

    always_comb begin
        logic                  blocked;
        logic                  send;
        logic                  done_cur;
        logic [COUNT_BITS:0]   v_end;
        logic [THR_BITS-1:0]   v_limit;
        logic [WIN_BITS:0]     v_dbl;

        n_cwnd    = r_cwnd;
        n_sst     = r_sst;
        n_mode    = r_mode;
        n_tmo     = r_tmo;
        n_acked   = r_acked;
        n_start   = r_start;
        n_sent    = r_sent;
        n_lostcnt = r_lostcnt;
        n_aal     = r_aal;
        n_open    = r_open;
        status    = ST_NOT_SENT;
        reacted   = 1'b0;
        blocked   = 1'b0;
        send      = 1'b0;
        v_end     = '0;
        v_limit   = (r_dup_thr == '0) ? THR_BITS'(1) : r_dup_thr;
        v_dbl     = {r_cwnd, 1'b0};
        done_cur  = EW'(r_acked) >= EW'(r_total);

        if (i_accept) begin
            unique case (i_op)
                OP_RESTART: begin
                    n_cwnd    = r_init_cwnd;
                    n_sst     = r_init_sst;
                    n_mode    = MODE_SLOW_START;
                    n_tmo     = '0;
                    n_acked   = '0;
                    n_start   = '0;
                    n_sent    = '0;
                    n_lostcnt = '0;
                    n_aal     = '0;
                    n_open    = 1'b0;
                end
                OP_PACKET: begin
                    if (i_first) begin
                        if (r_tmo != '0 || done_cur) begin
                            n_open  = 1'b0;
                            blocked = 1'b1;
                        end else begin
                            n_lostcnt = '0;
                            n_aal     = '0;
                            n_start   = r_acked;
                            n_sent    = '0;
                            n_open    = 1'b1;
                        end
                    end
                    v_end = {1'b0, n_start} + {1'b0, n_sent};
                    send  = !blocked && n_open && (EW'(n_sent) < EW'(r_cwnd))
                            && (EW'(v_end) < EW'(r_total));
                    if (send) begin
                        if (n_sent != '1) begin
                            n_sent = n_sent + 1'b1;
                        end
                        if (i_lost) begin
                            if (n_lostcnt != '1) begin
                                n_lostcnt = n_lostcnt + 1'b1;
                            end
                            status = ST_LOST;
                        end else if (n_lostcnt == '0) begin
                            if (n_acked != '1) begin
                                n_acked = n_acked + 1'b1;
                            end
                            status = ST_ACKED;
                        end else begin
                            if (n_aal != '1) begin
                                n_aal = n_aal + 1'b1;
                            end
                            // close the round once enough acks follow the loss
                            if (n_aal == v_limit) begin
                                n_open = 1'b0;
                                status = ST_THRESHOLD;
                            end else begin
                                status = ST_DUP_ACK;
                            end
                        end
                    end
                end
                OP_LOSS_CHECK: begin
                    priority if (r_tmo != '0) begin
                        n_tmo   = r_tmo - 1'b1;
                        reacted = 1'b1;
                    end else if (r_aal >= v_limit) begin
                        n_mode  = MODE_FAST_RETX;
                        n_sst   = r_cwnd >> 1;
                        n_cwnd  = r_fast_rec ? (r_cwnd >> 1) : WIN_BITS'(1);
                        reacted = 1'b1;
                    end else if (r_lostcnt != '0) begin
                        n_tmo   = r_tmo_wait;
                        n_mode  = MODE_SLOW_START;
                        n_sst   = r_cwnd >> 1;
                        n_cwnd  = WIN_BITS'(1);
                        reacted = 1'b1;
                    end else begin
                        reacted = 1'b0;
                    end
                end
                OP_RTT_TICK: begin
                    if (r_mode == MODE_FAST_RETX || r_mode == MODE_ADDITIVE) begin
                        n_mode = MODE_ADDITIVE;
                        if (r_cwnd != '1) begin
                            n_cwnd = r_cwnd + 1'b1;
                        end
                    end else if (r_mode == MODE_SLOW_START) begin
                        if (v_dbl > {1'b0, r_sst}) begin
                            n_cwnd = r_sst;
                        end else if (r_cwnd < r_sst) begin
                            n_cwnd = v_dbl[WIN_BITS-1:0];
                        end
                        if (n_cwnd == r_sst) begin
                            n_mode = MODE_ADDITIVE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_result.packet_status = status;
        o_result.loss_reacted  = reacted;
        o_result.window        = n_cwnd;
        o_result.threshold     = n_sst;
        o_result.cc_mode       = n_mode;
        o_result.acked_total   = WIN_BITS'(n_acked);
        o_result.timeout_left  = n_tmo;
        o_result.all_acked     = EW'(n_acked) >= EW'(r_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= TOTAL_RST;
            r_dup_thr   <= DUP_THR_RST;
            r_tmo_wait  <= TMO_WAIT_RST;
            r_fast_rec  <= FAST_REC_RST;
            r_init_cwnd <= INIT_CWND_RST;
            r_init_sst  <= INIT_SST_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_TOTAL_PACKETS:    r_total     <= i_cfg.data[WIN_BITS-1:0];
                CFG_DUP_ACK_THRESH:   r_dup_thr   <= i_cfg.data[THR_BITS-1:0];
                CFG_TIMEOUT_WAIT:     r_tmo_wait  <= i_cfg.data[TMO_BITS-1:0];
                CFG_FAST_RECOVERY:    r_fast_rec  <= i_cfg.data[0];
                CFG_INITIAL_CWND:     r_init_cwnd <= i_cfg.data[WIN_BITS-1:0];
                CFG_INITIAL_SSTHRESH: r_init_sst  <= i_cfg.data[WIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd    <= INIT_CWND_RST;
            r_sst     <= INIT_SST_RST;
            r_mode    <= MODE_SLOW_START;
            r_tmo     <= '0;
            r_acked   <= '0;
            r_start   <= '0;
            r_sent    <= '0;
            r_lostcnt <= '0;
            r_aal     <= '0;
            r_open    <= 1'b0;
        end else begin
            r_cwnd    <= n_cwnd;
            r_sst     <= n_sst;
            r_mode    <= n_mode;
            r_tmo     <= n_tmo;
            r_acked   <= n_acked;
            r_start   <= n_start;
            r_sent    <= n_sent;
            r_lostcnt <= n_lostcnt;
            r_aal     <= n_aal;
            r_open    <= n_open;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tcrw_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcrw_outbuf: result register with skid stage
// Two-entry output buffer; takes a result while an earlier one waits.
// ----------------------------------------------------------------------------
module tcrw_outbuf import tcrw_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                // advance the held transaction, or drain
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule
`default_nettype wire

FILE: sv/tcp_reno_congestion_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_reno_congestion_window: Reno congestion window engine
// Event-driven sender window with slow start, additive increase, fast
// retransmit and timeout handling.
// ----------------------------------------------------------------------------
// One event is taken per clock cycle while the input is ready; each yields
// one result, registered in the output buffer for the output channel. The
// event logic updates the window state in a single pass, so consecutive
// events see each other's effect without bubbles. A two-entry output buffer
// keeps the input ready while one result waits; the input stalls only when
// both entries are full. Write registers through the write port only while
// no event is in flight, not enforced here; unused indexes are ignored.
module tcp_reno_congestion_window import tcrw_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    tcrw_in_if.sink                       i_in,
    tcrw_out_if.source                    o_out
);

    t_cfg_wr cfg;
    t_result eng_result;
    t_result buf_result;
    logic    in_ready;
    logic    accept;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    tcrw_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_op     (t_op'(i_in.op)),
        .i_lost   (i_in.lost),
        .i_first  (i_in.first_of_round),
        .o_result (eng_result)
    );

    tcrw_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (eng_result),
        .o_ready (in_ready),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (buf_result)
    );

    assign o_out.packet_status = buf_result.packet_status;
    assign o_out.loss_reacted  = buf_result.loss_reacted;
    assign o_out.window        = buf_result.window;
    assign o_out.threshold     = buf_result.threshold;
    assign o_out.cc_mode       = buf_result.cc_mode;
    assign o_out.acked_total   = buf_result.acked_total;
    assign o_out.timeout_left  = buf_result.timeout_left;
    assign o_out.all_acked     = buf_result.all_acked;

endmodule
`default_nettype wire
